// ===== rtl/core/lrc_pkg.sv =====
package lrc_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned RowW      = 12;
  localparam int unsigned WsumW     = 32;
  localparam int unsigned WtW       = 20;
  localparam int unsigned FracW     = 8;
  localparam int unsigned NumW      = WsumW + FracW;
  localparam int unsigned QW        = 21;
  localparam int unsigned DivSteps  = NumW;
  localparam int unsigned StepW     = 6;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [PixW-1:0]  ThresholdReset = 8'd127;
  localparam logic [AddrW-1:0] AddrThreshold  = 3'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic row_end_nz;
    logic last_step;
  } sts_t;

endpackage

// ===== rtl/core/lrc_cfg.sv =====
module lrc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrc_pkg::AddrW-1:0]   paddr,
  input  logic [lrc_pkg::DataW-1:0]   pwdata,
  output logic [lrc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output logic [lrc_pkg::PixW-1:0]    threshold
);

  logic [lrc_pkg::PixW-1:0] threshold_r;
  logic [lrc_pkg::PixW-1:0] threshold_nxt;
  logic                     wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel & penable & pwrite & (paddr == lrc_pkg::AddrThreshold);

  always_comb begin
    threshold_nxt = threshold_r;
    if (wr_hit) begin
      threshold_nxt = pwdata[lrc_pkg::PixW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= lrc_pkg::ThresholdReset;
    end else begin
      threshold_r <= threshold_nxt;
    end
  end

  always_comb begin
    unique case (paddr)
      lrc_pkg::AddrThreshold: prdata = {{(lrc_pkg::DataW-lrc_pkg::PixW){1'b0}}, threshold_r};
      default:                prdata = '0;
    endcase
  end

  assign threshold = threshold_r;

endmodule

// ===== rtl/core/lrc_ctrl.sv =====
module lrc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  lrc_pkg::sts_t sts,
  input  logic          out_stall,
  output lrc_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  lrc_pkg::state_t state_r;
  lrc_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_free;

  // The output register can take a new beat when it is empty or drains now.
  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    busy          = 1'b1;
    out_valid_nxt = out_valid_r & out_stall;
    unique case (state_r)
      lrc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (sts.row_end_nz) begin
          cmd.load  = 1'b1;
          state_nxt = lrc_pkg::ST_DIV;
        end
      end
      lrc_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.last_step) begin
          if (out_free) begin
            cmd.capture   = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = lrc_pkg::ST_IDLE;
          end else begin
            state_nxt = lrc_pkg::ST_OUT;
          end
        end
      end
      // The quotient is final but the output register still holds an unread beat.
      lrc_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/lrc_datapath.sv =====
module lrc_datapath #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_accept,
  input  logic [lrc_pkg::PixW-1:0]   pixel,
  input  logic                       last_in_row,
  input  logic                       last_in_frame,
  input  logic [lrc_pkg::PixW-1:0]   threshold,
  input  lrc_pkg::cmd_t              cmd,
  output lrc_pkg::sts_t              sts,
  output logic [lrc_pkg::RowW-1:0]   row_index,
  output logic [lrc_pkg::QW-1:0]     centroid_q8
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ProdW = lrc_pkg::PixW + ColW;

  logic [lrc_pkg::WsumW-1:0] wsum_r, wsum_nxt, wsum_add;
  logic [lrc_pkg::WtW-1:0]   wt_r, wt_nxt, wt_add;
  logic [ColW-1:0]           col_r, col_nxt, col_plus;
  logic [lrc_pkg::RowW-1:0]  row_r, row_nxt;
  logic                      col_ok;
  logic                      hit;
  logic                      row_end;
  logic [ProdW-1:0]          prod;

  logic [lrc_pkg::NumW-1:0]  quo_r, quo_nxt;
  logic [lrc_pkg::WtW-1:0]   rem_r, rem_nxt;
  logic [lrc_pkg::WtW-1:0]   den_r, den_nxt;
  logic [lrc_pkg::RowW-1:0]  job_row_r, job_row_nxt;
  logic [lrc_pkg::StepW-1:0] step_r, step_nxt;
  logic [lrc_pkg::WtW:0]     trial;
  logic                      fits;
  logic [lrc_pkg::RowW-1:0]  row_out_r, row_out_nxt;
  logic [lrc_pkg::QW-1:0]    cent_out_r, cent_out_nxt;

  assign col_ok   = col_r < ColW'(MAX_WIDTH);
  assign col_plus = col_r + 1'b1;
  assign hit      = col_ok & (pixel > threshold);
  assign prod     = ProdW'(pixel) * ProdW'(col_plus);
  assign wsum_add = wsum_r + (hit ? lrc_pkg::WsumW'(prod) : '0);
  assign wt_add   = wt_r + (hit ? lrc_pkg::WtW'(pixel) : '0);
  assign row_end  = last_in_row | last_in_frame;

  assign sts.row_end_nz = in_accept & row_end & (wt_add != '0);
  assign sts.last_step  = step_r == lrc_pkg::StepW'(lrc_pkg::DivSteps - 1);

  always_comb begin
    wsum_nxt = wsum_r;
    wt_nxt   = wt_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (in_accept) begin
      if (row_end) begin
        wsum_nxt = '0;
        wt_nxt   = '0;
        col_nxt  = '0;
        if (last_in_frame || row_r == lrc_pkg::RowW'(MAX_HEIGHT - 1)) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        wsum_nxt = wsum_add;
        wt_nxt   = wt_add;
        if (col_ok) begin
          col_nxt = col_plus;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsum_r <= '0;
      wt_r   <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      wsum_r <= wsum_nxt;
      wt_r   <= wt_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

  // Restoring division, one quotient bit per cycle. The dividend shifts out of
  // the top of quo_r while quotient bits shift in at the bottom.
  assign trial = {rem_r, quo_r[lrc_pkg::NumW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    den_nxt     = den_r;
    job_row_nxt = job_row_r;
    step_nxt    = step_r;
    if (cmd.load) begin
      quo_nxt     = {wsum_add, {lrc_pkg::FracW{1'b0}}};
      rem_nxt     = '0;
      den_nxt     = wt_add;
      job_row_nxt = row_r;
      step_nxt    = '0;
    end else if (cmd.step) begin
      rem_nxt  = fits ? lrc_pkg::WtW'(trial - {1'b0, den_r}) : trial[lrc_pkg::WtW-1:0];
      quo_nxt  = {quo_r[lrc_pkg::NumW-2:0], fits};
      step_nxt = step_r + 1'b1;
    end
  end

  // The output register takes the final quotient, either on the last divide
  // step or later once the receiver has drained the previous beat.
  always_comb begin
    row_out_nxt  = row_out_r;
    cent_out_nxt = cent_out_r;
    if (cmd.capture) begin
      row_out_nxt  = job_row_r;
      cent_out_nxt = quo_nxt[lrc_pkg::QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    job_row_r  <= job_row_nxt;
    step_r     <= step_nxt;
    row_out_r  <= row_out_nxt;
    cent_out_r <= cent_out_nxt;
  end

  assign row_index   = row_out_r;
  assign centroid_q8 = cent_out_r;

endmodule

// ===== rtl/core/laser_line_row_centroid_unit.sv =====
// Gray-weighted laser stripe centroid, at most one result per row.
// Input channel: one pixel per beat in raster order, with row and frame end
// marks. Pixels above the threshold register accumulate at one beat per clock.
// Result channel: row index and Q.8 centroid for each row that had at least
// one bright pixel; rows without one produce no beat.
// Division: once the beat ending a row is taken, the restoring divider (one
// quotient bit per cycle) works out the centroid, and an output register
// then holds the result beat.
// Throughput: pixels flow at one per clock. A row-end beat is stalled while the
// divider works on the previous row or holds a finished quotient that the full
// output register cannot take yet, so rows of at least 41 pixels run without
// stalls when the receiver keeps up. Other pixels are never stalled.
// A receiver stall holds the result beat steady; a stall that outlasts the next
// division also holds the following row-end beat on the input.
// Reset (synchronous, active low) clears the sums, column and row counters,
// drops any pending result and sets the threshold back to 127.
// Configuration: APB register at address 0 holds the threshold; write it only
// while the block is idle.
module laser_line_row_centroid_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_pixel,
  input  logic                        in_last_in_row,
  input  logic                        in_last_in_frame,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [11:0]                 out_row_index,
  output logic [20:0]                 out_centroid_q8,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrc_pkg::AddrW-1:0]   paddr,
  input  logic [lrc_pkg::DataW-1:0]   pwdata,
  output logic [lrc_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  logic [lrc_pkg::PixW-1:0] threshold;
  lrc_pkg::cmd_t            cmd;
  lrc_pkg::sts_t            sts;
  logic                     busy;
  logic                     in_accept;

  assign in_stall  = busy & (in_last_in_row | in_last_in_frame);
  assign in_accept = in_valid & ~in_stall;

  lrc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  lrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .out_stall (out_stall),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  lrc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .pixel         (in_pixel),
    .last_in_row   (in_last_in_row),
    .last_in_frame (in_last_in_frame),
    .threshold     (threshold),
    .cmd           (cmd),
    .sts           (sts),
    .row_index     (out_row_index),
    .centroid_q8   (out_centroid_q8)
  );

endmodule

// ===== rtl/core/lrc_checker.sv =====
module lrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        in_last_in_row,
  input logic        in_last_in_frame,
  input logic        out_valid,
  input logic        out_stall,
  input logic [20:0] out_centroid_q8,
  input logic [11:0] out_row_index
);

  // Only beats that close a row ever wait on the divider.
  a_stall_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_last_in_row | in_last_in_frame))
    else $error("input stalled on a beat that does not end a row");

  // A centroid is one-based, so it lies between column 1 and column 4096.
  a_centroid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_centroid_q8 >= 21'd256 && out_centroid_q8 <= 21'd1048576))
    else $error("centroid out of range");

  // Reset drops any pending result beat.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat offered right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_centroid_q8)
                                  && $stable(out_row_index)))
    else $error("stalled result beat changed");

endmodule

bind laser_line_row_centroid_unit lrc_checker u_lrc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .in_last_in_row   (in_last_in_row),
  .in_last_in_frame (in_last_in_frame),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_centroid_q8  (out_centroid_q8),
  .out_row_index    (out_row_index)
);

// ===== tb/sv/tb_laser_line_row_centroid_unit.sv =====
module tb_laser_line_row_centroid_unit;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned DrainTail  = 60;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned MaxPrinted = 100;

  typedef struct packed {
    logic [lrc_pkg::PixW-1:0] pixel;
    logic                     row_end;
    logic                     frame_end;
  } pixel_beat_t;

  typedef struct packed {
    logic [lrc_pkg::RowW-1:0] row;
    logic [lrc_pkg::QW-1:0]   centroid;
  } row_centroid_t;

  logic                        clk              = 1'b0;
  logic                        rst_n            = 1'b0;
  logic                        in_valid         = 1'b0;
  logic                        in_stall;
  logic [lrc_pkg::PixW-1:0]    in_pixel         = '0;
  logic                        in_last_in_row   = 1'b0;
  logic                        in_last_in_frame = 1'b0;
  logic                        out_valid;
  logic                        out_stall        = 1'b0;
  logic [lrc_pkg::RowW-1:0]    out_row_index;
  logic [lrc_pkg::QW-1:0]      out_centroid_q8;
  logic                        psel             = 1'b0;
  logic                        penable          = 1'b0;
  logic                        pwrite           = 1'b0;
  logic [lrc_pkg::AddrW-1:0]   paddr            = '0;
  logic [lrc_pkg::DataW-1:0]   pwdata           = '0;
  logic [lrc_pkg::DataW-1:0]   prdata;
  logic                        pready;

  laser_line_row_centroid_unit #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .in_last_in_row  (in_last_in_row),
    .in_last_in_frame(in_last_in_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_centroid_q8 (out_centroid_q8),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state, a copy of what the block should hold.
  logic [lrc_pkg::PixW-1:0]  thr_model    = lrc_pkg::ThresholdReset;
  logic [lrc_pkg::WsumW-1:0] acc_weighted = '0;
  logic [lrc_pkg::WtW-1:0]   acc_weight   = '0;
  logic [12:0]               col_seen     = '0;
  logic [lrc_pkg::RowW-1:0]  row_now      = '0;

  pixel_beat_t   pending_pix[$];
  row_centroid_t exp_centroids[$];
  int unsigned   queued_items = 0;
  int unsigned   beats_done   = 0;
  int unsigned   err_count    = 0;
  bit            idle_on      = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MaxPrinted) begin
      $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
    end
    err_count++;
  endtask

  function automatic void predict_row_centroid(input pixel_beat_t b);
    logic [lrc_pkg::NumW-1:0] num;
    logic [lrc_pkg::NumW-1:0] quo;
    row_centroid_t            r;
    // Columns past the maximum width leave the sums and the count alone.
    if (col_seen < 13'(MaxWidth)) begin
      col_seen = col_seen + 13'd1;
      if (b.pixel > thr_model) begin
        acc_weighted = acc_weighted + lrc_pkg::WsumW'(b.pixel) * lrc_pkg::WsumW'(col_seen);
        acc_weight   = acc_weight + lrc_pkg::WtW'(b.pixel);
      end
    end
    // A frame end also closes the row, before the row counter restarts.
    if (b.row_end || b.frame_end) begin
      if (acc_weight != '0) begin
        num = {acc_weighted, {lrc_pkg::FracW{1'b0}}};
        quo = num / lrc_pkg::NumW'(acc_weight);
        r.row      = row_now;
        r.centroid = quo[lrc_pkg::QW-1:0];
        exp_centroids.insert(exp_centroids.size(), r);
      end
      acc_weighted = '0;
      acc_weight   = '0;
      col_seen     = '0;
      if (int'(row_now) + 1 >= int'(MaxHeight)) begin
        row_now = '0;
      end else begin
        row_now = row_now + 1'b1;
      end
    end
    if (b.frame_end) begin
      row_now = '0;
    end
  endfunction

  // Pixel driver.
  pixel_beat_t on_bus = '0;
  int unsigned in_gap = 0;

  always @(posedge clk) begin
    logic        nxt_valid;
    pixel_beat_t nxt;
    if (rst_n) begin
      nxt_valid = in_valid;
      nxt       = on_bus;
      if (in_valid && !in_stall) begin
        beats_done++;
        predict_row_centroid(on_bus);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 7) - 1;
        end else if (pending_pix.size() != 0) begin
          nxt       = pending_pix.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid         <= nxt_valid;
      on_bus           <= nxt;
      in_pixel         <= nxt.pixel;
      in_last_in_row   <= nxt.row_end;
      in_last_in_frame <= nxt.frame_end;
    end
  end

  // Result monitor and receiver stall.
  int unsigned out_gap = 0;

  always @(posedge clk) begin
    row_centroid_t want;
    logic          nxt_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (exp_centroids.size() == 0) begin
          report_mismatch("result beat with nothing expected", out_row_index, 0);
        end else begin
          want = exp_centroids.pop_front();
          if (out_row_index !== want.row) begin
            report_mismatch("row_index", out_row_index, want.row);
          end
          if (out_centroid_q8 !== want.centroid) begin
            report_mismatch("centroid_q8", out_centroid_q8, want.centroid);
          end
        end
      end
      nxt_stall = 1'b0;
      if (out_gap != 0) begin
        nxt_stall = 1'b1;
        out_gap--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        nxt_stall = 1'b1;
        out_gap   = $urandom_range(1, 7) - 1;
      end
      out_stall <= nxt_stall;
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_beat(input int v, input bit row_end, input bit frame_end);
    pixel_beat_t b;
    b.pixel     = lrc_pkg::PixW'(v);
    b.row_end   = row_end;
    b.frame_end = frame_end;
    pending_pix.insert(pending_pix.size(), b);
    queued_items++;
  endtask

  task automatic wait_drained();
    while (beats_done != queued_items || exp_centroids.size() != 0) begin
      @(posedge clk);
    end
    // Let the block settle before the next configuration write.
    repeat (DrainTail) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [lrc_pkg::PixW-1:0] val);
    logic [lrc_pkg::DataW-1:0] junk;
    junk = lrc_pkg::DataW'($urandom());
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lrc_pkg::AddrThreshold;
    pwdata  <= {junk[lrc_pkg::DataW-1:lrc_pkg::PixW], val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    thr_model = val;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== lrc_pkg::DataW'(val)) begin
      report_mismatch("threshold read back", prdata, val);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One row of a stripe image: mostly a bright band on a dark background,
  // sometimes pure noise or an all-dark row, rarely a stray end mark.
  task automatic queue_row(input int width, input bit row_mark, input bit frame_mark);
    int centre;
    int half;
    int mode;
    int v;
    bit re;
    bit fe;
    mode   = $urandom_range(0, 7);
    centre = $urandom_range(1, width);
    half   = $urandom_range(0, 4);
    for (int c = 1; c <= width; c++) begin
      if (mode == 0) begin
        v = $urandom_range(0, 255);
      end else if (mode == 1) begin
        v = $urandom_range(0, thr_model);
      end else if (c >= centre - half && c <= centre + half) begin
        v = $urandom_range(int'(thr_model), 255);
      end else begin
        v = $urandom_range(0, 40);
      end
      re = (c == width) ? row_mark : 1'b0;
      fe = (c == width) ? frame_mark : 1'b0;
      if (c != width && $urandom_range(0, 149) == 0) begin
        re = 1'($urandom_range(0, 1));
        fe = !re;
      end
      push_beat(v, re, fe);
    end
  endtask

  // A frame of random rows; it closes early so that no more than goal items
  // are queued in total.
  task automatic queue_frame(input int unsigned goal);
    int rows;
    int width;
    bit last;
    rows = $urandom_range(1, 10);
    for (int r = 0; r < rows; r++) begin
      width = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 300) : $urandom_range(1, 48);
      if (int'(queued_items) + width >= int'(goal)) begin
        width = int'(goal) - int'(queued_items);
      end
      last = (r == rows - 1) || (int'(queued_items) + width >= int'(goal));
      if (last) begin
        queue_row(width, 1'($urandom_range(0, 1)), 1'b1);
        break;
      end else begin
        queue_row(width, 1'b1, 1'b0);
      end
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned goal;
    goal = queued_items + n;
    while (queued_items < goal) begin
      queue_frame(goal);
    end
    wait_drained();
  endtask

  task automatic queue_directed();
    // Threshold itself does not count, one above does; both pixel extremes.
    push_beat(127, 1'b0, 1'b0);
    push_beat(128, 1'b0, 1'b0);
    push_beat(0, 1'b0, 1'b0);
    push_beat(255, 1'b1, 1'b0);
    // A row with no bright pixel gives no result.
    push_beat(127, 1'b0, 1'b0);
    push_beat(0, 1'b0, 1'b0);
    push_beat(100, 1'b1, 1'b0);
    push_beat(255, 1'b1, 1'b0);
    // Frame end without a row mark still closes and reports the row.
    push_beat(200, 1'b0, 1'b0);
    push_beat(50, 1'b0, 1'b0);
    push_beat(255, 1'b0, 1'b1);
    push_beat(255, 1'b1, 1'b1);
    push_beat(255, 1'b0, 1'b0);
    push_beat(10, 1'b0, 1'b0);
    push_beat(10, 1'b0, 1'b0);
    push_beat(10, 1'b1, 1'b0);
    push_beat(0, 1'b0, 1'b1);
  endtask

  initial begin
    queue_directed();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    set_threshold(8'd0);
    run_random(220);
    set_threshold(8'd255);
    run_random(100);
    repeat (4) begin
      set_threshold(lrc_pkg::PixW'($urandom_range(30, 230)));
      run_random(220);
    end
    set_threshold(8'd1);
    run_random(150);
    set_threshold(8'd254);
    run_random(150);

    idle_on = 1'b0;
    set_threshold(lrc_pkg::PixW'($urandom_range(0, 255)));
    run_random(130);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
